>>> hdl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising clock, off while reset is asserted.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("alarm monitor check failed");

// Signal holds for the cycle after the condition.
`define ASSERT_HOLD(lbl, clk, rst_n, cond, sig) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> $stable(sig)) \
		else $error("alarm monitor hold check failed");

`endif

>>> hdl/swam_pkg.sv
package swam_pkg;

	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;
	localparam int FIELD_W = 32;

	typedef enum logic [2:0] {
		ST_NONE  = 3'd0,
		ST_HIHI  = 3'd1,
		ST_LOLO  = 3'd2,
		ST_HIGH  = 3'd3,
		ST_LOW   = 3'd4,
		ST_UNDEF = 3'd5
	} alarm_status_t;

	typedef enum logic [1:0] {
		SEV_NONE    = 2'd0,
		SEV_MINOR   = 2'd1,
		SEV_MAJOR   = 2'd2,
		SEV_INVALID = 2'd3
	} alarm_severity_t;

	typedef enum logic [2:0] {
		REG_HIHI     = 3'd0,
		REG_HIGH     = 3'd1,
		REG_LOW      = 3'd2,
		REG_LOLO     = 3'd3,
		REG_HYST     = 3'd4,
		REG_SEVS     = 3'd5,
		REG_VALUE_DB = 3'd6,
		REG_ARCH_DB  = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [FIELD_W-1:0] hihi_limit;
		logic [FIELD_W-1:0] high_limit;
		logic [FIELD_W-1:0] low_limit;
		logic [FIELD_W-1:0] lolo_limit;
		logic [30:0]        hysteresis;
		logic [7:0]         alarm_severities;
		logic [FIELD_W-1:0] value_deadband;
		logic [FIELD_W-1:0] archive_deadband;
	} cfg_t;

	typedef struct packed {
		alarm_status_t      status;
		alarm_severity_t    severity;
		logic [FIELD_W-1:0] level;
	} grade_t;

endpackage

>>> hdl/swam_regs.sv
module swam_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [swam_pkg::ADDR_W-1:0] paddr,
	input  logic [swam_pkg::DATA_W-1:0] pwdata,
	output logic [swam_pkg::DATA_W-1:0] prdata,
	output logic                        pready,
	output swam_pkg::cfg_t              cfg
);
	import swam_pkg::*;

	reg_idx_t idx;
	logic     wr_en;
	cfg_t     cfg_q;

	assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (idx)
				REG_HIHI: begin
					cfg_q.hihi_limit <= pwdata;
				end
				REG_HIGH: begin
					cfg_q.high_limit <= pwdata;
				end
				REG_LOW: begin
					cfg_q.low_limit <= pwdata;
				end
				REG_LOLO: begin
					cfg_q.lolo_limit <= pwdata;
				end
				REG_HYST: begin
					cfg_q.hysteresis <= pwdata[30:0];
				end
				REG_SEVS: begin
					cfg_q.alarm_severities <= pwdata[7:0];
				end
				REG_VALUE_DB: begin
					cfg_q.value_deadband <= pwdata;
				end
				REG_ARCH_DB: begin
					cfg_q.archive_deadband <= pwdata;
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_HIHI:     prdata = cfg_q.hihi_limit;
			REG_HIGH:     prdata = cfg_q.high_limit;
			REG_LOW:      prdata = cfg_q.low_limit;
			REG_LOLO:     prdata = cfg_q.lolo_limit;
			REG_HYST:     prdata = {1'b0, cfg_q.hysteresis};
			REG_SEVS:     prdata = {24'd0, cfg_q.alarm_severities};
			REG_VALUE_DB: prdata = cfg_q.value_deadband;
			REG_ARCH_DB:  prdata = cfg_q.archive_deadband;
			default:      prdata = '0;
		endcase
	end

endmodule

>>> hdl/swam_grade.sv
module swam_grade (
	input  swam_pkg::cfg_t                     cfg,
	input  logic signed [swam_pkg::FIELD_W-1:0] v,
	input  logic                               defined,
	input  logic        [swam_pkg::FIELD_W-1:0] last_level,
	output swam_pkg::grade_t                   grade
);
	import swam_pkg::*;

	logic signed [FIELD_W:0]   v33;
	logic signed [FIELD_W:0]   hyst33;
	logic signed [FIELD_W-1:0] hihi, lolo, high, low;
	alarm_severity_t           sev_hh, sev_ll, sev_h, sev_l;
	logic                      trip_hh, trip_ll, trip_h, trip_l;

	assign hihi   = $signed(cfg.hihi_limit);
	assign lolo   = $signed(cfg.lolo_limit);
	assign high   = $signed(cfg.high_limit);
	assign low    = $signed(cfg.low_limit);
	assign v33    = (FIELD_W+1)'(v);
	assign hyst33 = $signed({2'b00, cfg.hysteresis});

	assign sev_hh = alarm_severity_t'(cfg.alarm_severities[1:0]);
	assign sev_ll = alarm_severity_t'(cfg.alarm_severities[3:2]);
	assign sev_h  = alarm_severity_t'(cfg.alarm_severities[5:4]);
	assign sev_l  = alarm_severity_t'(cfg.alarm_severities[7:6]);

	// Hold an alarm inside the band while the last level still sits on that limit.
	assign trip_hh = (sev_hh != SEV_NONE) && ((v >= hihi) ||
		((last_level == cfg.hihi_limit) && (v33 >= (FIELD_W+1)'(hihi) - hyst33)));
	assign trip_ll = (sev_ll != SEV_NONE) && ((v <= lolo) ||
		((last_level == cfg.lolo_limit) && (v33 <= (FIELD_W+1)'(lolo) + hyst33)));
	assign trip_h  = (sev_h != SEV_NONE) && ((v >= high) ||
		((last_level == cfg.high_limit) && (v33 >= (FIELD_W+1)'(high) - hyst33)));
	assign trip_l  = (sev_l != SEV_NONE) && ((v <= low) ||
		((last_level == cfg.low_limit) && (v33 <= (FIELD_W+1)'(low) + hyst33)));

	always_comb begin
		grade.status   = ST_NONE;
		grade.severity = SEV_NONE;
		grade.level    = v;
		if (!defined) begin
			grade.status   = ST_UNDEF;
			grade.severity = SEV_INVALID;
			grade.level    = last_level;
		end else if (trip_hh) begin
			grade.status   = ST_HIHI;
			grade.severity = sev_hh;
			grade.level    = cfg.hihi_limit;
		end else if (trip_ll) begin
			grade.status   = ST_LOLO;
			grade.severity = sev_ll;
			grade.level    = cfg.lolo_limit;
		end else if (trip_h) begin
			grade.status   = ST_HIGH;
			grade.severity = sev_h;
			grade.level    = cfg.high_limit;
		end else if (trip_l) begin
			grade.status   = ST_LOW;
			grade.severity = sev_l;
			grade.level    = cfg.low_limit;
		end
	end

endmodule

>>> hdl/status_word_alarm_monitor_core.sv
// Status word alarm monitor. Each request carries a signed status word and a
// defined flag; the block grades it against the hihi, lolo, high and low limits
// (checked in that order, one shared hysteresis band), reports value and
// archive deadband events, and gives a link mask of changed bits, or all ones
// over VALUE_WIDTH bits when the alarm status or severity changes. Only the low
// VALUE_WIDTH bits of value are used, sign extended. One request is accepted
// every cycle while in_ready is high; the request is captured in the input
// register, and the grading and deadband logic feeds the result register from
// it. A result held by out_ready low holds the input register, and in_ready
// drops once both are full. The alarm and deadband history updates when the
// result register is written, so back-to-back requests see each other's
// history. Limits are written over the APB port at byte address 4*index and
// take effect for requests graded after.
module status_word_alarm_monitor_core #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [swam_pkg::ADDR_W-1:0]  paddr,
	input  logic [swam_pkg::DATA_W-1:0]  pwdata,
	output logic [swam_pkg::DATA_W-1:0]  prdata,
	output logic                         pready,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic signed [swam_pkg::FIELD_W-1:0] value,
	input  logic                         value_defined,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [2:0]                   alarm_status,
	output logic [1:0]                   alarm_severity,
	output logic                         alarm_changed,
	output logic                         value_event,
	output logic                         archive_event,
	output logic [swam_pkg::FIELD_W-1:0] link_mask
);
	import swam_pkg::*;

	localparam logic [FIELD_W-1:0] WMASK =
		FIELD_W'((64'd1 << VALUE_WIDTH) - 64'd1);

	cfg_t                      cfg;
	grade_t                    grade;

	logic signed [VALUE_WIDTH-1:0] value_nar;
	logic signed [FIELD_W-1:0] value_ext;

	logic                      valid_s1;
	logic signed [FIELD_W-1:0] value_s1;
	logic                      defined_s1;
	logic                      advance;

	logic [FIELD_W-1:0]        last_level_q;
	alarm_status_t             prev_status_q;
	alarm_severity_t           prev_sev_q;
	logic signed [FIELD_W-1:0] monitor_last_q;
	logic signed [FIELD_W-1:0] archive_last_q;
	logic signed [FIELD_W-1:0] last_value_q;

	logic signed [FIELD_W+1:0] d_mon, d_arc, db_mon, db_arc;
	logic                      changed, vev, aev;
	logic [FIELD_W-1:0]        links;

	logic                      out_valid_q;
	logic [2:0]                status_q;
	logic [1:0]                severity_q;
	logic                      changed_q, vev_q, aev_q;
	logic [FIELD_W-1:0]        links_q;

	swam_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign value_nar = value[VALUE_WIDTH-1:0];
	assign value_ext = FIELD_W'(value_nar);

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			value_s1   <= value_ext;
			defined_s1 <= value_defined;
		end
	end

	swam_grade u_grade (
		.cfg        (cfg),
		.v          (value_s1),
		.defined    (defined_s1),
		.last_level (last_level_q),
		.grade      (grade)
	);

	assign d_mon  = (FIELD_W+2)'(monitor_last_q) - (FIELD_W+2)'(value_s1);
	assign d_arc  = (FIELD_W+2)'(archive_last_q) - (FIELD_W+2)'(value_s1);
	assign db_mon = (FIELD_W+2)'($signed(cfg.value_deadband));
	assign db_arc = (FIELD_W+2)'($signed(cfg.archive_deadband));

	assign vev = (d_mon > db_mon) || (-d_mon > db_mon);
	assign aev = (d_arc > db_arc) || (-d_arc > db_arc);

	assign changed = (grade.status != prev_status_q) || (grade.severity != prev_sev_q);
	assign links   = changed ? WMASK : ((value_s1 ^ last_value_q) & WMASK);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_level_q   <= '0;
			prev_status_q  <= ST_NONE;
			prev_sev_q     <= SEV_NONE;
			monitor_last_q <= '0;
			archive_last_q <= '0;
			last_value_q   <= '0;
		end else if (advance) begin
			last_level_q  <= grade.level;
			prev_status_q <= grade.status;
			prev_sev_q    <= grade.severity;
			last_value_q  <= value_s1;
			if (vev) begin
				monitor_last_q <= value_s1;
			end
			if (aev) begin
				archive_last_q <= value_s1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			status_q   <= grade.status;
			severity_q <= grade.severity;
			changed_q  <= changed;
			vev_q      <= vev;
			aev_q      <= aev;
			links_q    <= links;
		end
	end

	assign out_valid      = out_valid_q;
	assign alarm_status   = status_q;
	assign alarm_severity = severity_q;
	assign alarm_changed  = changed_q;
	assign value_event    = vev_q;
	assign archive_event  = aev_q;
	assign link_mask      = links_q;

endmodule

>>> hdl/swam_check.sv
`include "assert_macros.svh"

module swam_check (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic [2:0]                   alarm_status,
	input logic [1:0]                   alarm_severity,
	input logic                         alarm_changed,
	input logic [swam_pkg::FIELD_W-1:0] link_mask
);
	import swam_pkg::*;

	`ASSERT_HOLD(a_out_hold, clk, arst_n, out_valid && !out_ready, {alarm_status, alarm_severity, link_mask})

	`ASSERT_CLK(a_undef_invalid, clk, arst_n, out_valid && (alarm_status == ST_UNDEF) |-> alarm_severity == SEV_INVALID)

	`ASSERT_CLK(a_none_pairs, clk, arst_n, out_valid |-> ((alarm_status == ST_NONE) == (alarm_severity == SEV_NONE)))

	`ASSERT_CLK(a_change_mask, clk, arst_n, out_valid && alarm_changed |-> link_mask[7:0] == 8'hff)

endmodule

bind status_word_alarm_monitor_core swam_check u_swam_check (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (out_valid),
	.out_ready      (out_ready),
	.alarm_status   (alarm_status),
	.alarm_severity (alarm_severity),
	.alarm_changed  (alarm_changed),
	.link_mask      (link_mask)
);

>>> tb/sv/tb_status_word_alarm_monitor_core.sv
module tb_status_word_alarm_monitor_core;
	timeunit 1ns;
	timeprecision 1ps;

	import swam_pkg::*;

	typedef struct {
		logic [31:0] word;
		logic        defined;
	} status_request_t;

	typedef struct {
		alarm_status_t   status;
		alarm_severity_t severity;
		logic            changed;
		logic            value_ev;
		logic            archive_ev;
		logic [31:0]     links;
	} alarm_result_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [ADDR_W-1:0]   paddr = '0;
	logic [DATA_W-1:0]   pwdata = '0;
	logic [DATA_W-1:0]   prdata;
	logic                pready;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic signed [31:0]  value = '0;
	logic                value_defined = 1'b0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [2:0]          alarm_status;
	logic [1:0]          alarm_severity;
	logic                alarm_changed;
	logic                value_event;
	logic                archive_event;
	logic [31:0]         link_mask;

	status_request_t pending_requests[$];
	alarm_result_t   expected_alarms[$];

	// limit shadow
	longint    lim_hihi = 0, lim_high = 0, lim_low = 0, lim_lolo = 0;
	longint    hyst_band = 0, value_db = 0, archive_db = 0;
	logic [7:0] sev_map = '0;

	// grading history
	longint          held_level = 0, value_mark = 0, archive_mark = 0;
	alarm_status_t   prev_status = ST_NONE;
	alarm_severity_t prev_severity = SEV_NONE;
	logic [31:0]     prev_word = '0;

	int              fail_count = 0;
	int              words_accepted = 0;
	int              send_gap = 0;
	int              ready_gap = 0;
	int              hold_left = 0;
	bit              hold_done = 1'b0;
	bit              calm = 1'b0;
	logic [31:0]     gen_last = '0;
	status_request_t next_request;
	alarm_result_t   oldest;

	status_word_alarm_monitor_core i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.value          (value),
		.value_defined  (value_defined),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.alarm_status   (alarm_status),
		.alarm_severity (alarm_severity),
		.alarm_changed  (alarm_changed),
		.value_event    (value_event),
		.archive_event  (archive_event),
		.link_mask      (link_mask)
	);

	always #5ns clk = ~clk;

	function automatic longint magnitude(input longint d);
		return (d < 0) ? -d : d;
	endfunction

	function automatic void grade_request(input logic [31:0] word, input logic defined);
		longint        v;
		alarm_result_t r;
		v = longint'($signed(word));
		r.status = ST_NONE;
		r.severity = SEV_NONE;
		r.value_ev = 1'b0;
		r.archive_ev = 1'b0;
		if (!defined) begin
			r.status = ST_UNDEF;
			r.severity = SEV_INVALID;
		end else if (sev_map[1:0] != 0 && (v >= lim_hihi ||
				(held_level == lim_hihi && v >= lim_hihi - hyst_band))) begin
			r.status = ST_HIHI;
			r.severity = alarm_severity_t'(sev_map[1:0]);
			held_level = lim_hihi;
		end else if (sev_map[3:2] != 0 && (v <= lim_lolo ||
				(held_level == lim_lolo && v <= lim_lolo + hyst_band))) begin
			r.status = ST_LOLO;
			r.severity = alarm_severity_t'(sev_map[3:2]);
			held_level = lim_lolo;
		end else if (sev_map[5:4] != 0 && (v >= lim_high ||
				(held_level == lim_high && v >= lim_high - hyst_band))) begin
			r.status = ST_HIGH;
			r.severity = alarm_severity_t'(sev_map[5:4]);
			held_level = lim_high;
		end else if (sev_map[7:6] != 0 && (v <= lim_low ||
				(held_level == lim_low && v <= lim_low + hyst_band))) begin
			r.status = ST_LOW;
			r.severity = alarm_severity_t'(sev_map[7:6]);
			held_level = lim_low;
		end else begin
			held_level = v;
		end
		r.changed = (r.status != prev_status) || (r.severity != prev_severity);
		prev_status = r.status;
		prev_severity = r.severity;
		if (magnitude(value_mark - v) > value_db) begin
			r.value_ev = 1'b1;
			value_mark = v;
		end
		if (magnitude(archive_mark - v) > archive_db) begin
			r.archive_ev = 1'b1;
			archive_mark = v;
		end
		r.links = r.changed ? 32'hffff_ffff : (word ^ prev_word);
		prev_word = word;
		expected_alarms.push_back(r);
	endfunction

	function automatic void check_field(input string what, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
			fail_count++;
		end
	endfunction

	function automatic status_request_t random_request();
		status_request_t r;
		longint          base, off, span, t;
		int              pick;
		pick = $urandom_range(0, 9);
		r.defined = ($urandom_range(0, 15) != 0);
		if (pick < 6) begin
			case ($urandom_range(0, 3))
				0: base = lim_hihi;
				1: base = lim_high;
				2: base = lim_low;
				default: base = lim_lolo;
			endcase
			span = (hyst_band > 1000) ? 1000 : hyst_band + 3;
			off = longint'($urandom_range(0, 6)) - 3;
			if ($urandom_range(0, 1))
				off += $urandom_range(0, 1) ? hyst_band : -hyst_band;
			else if ($urandom_range(0, 1))
				off = longint'($urandom_range(0, 2 * span)) - span;
			t = base + off;
			r.word = t[31:0];
		end else if (pick < 8) begin
			r.word = $urandom;
		end else if (pick == 8) begin
			case ($urandom_range(0, 3))
				0: r.word = 32'h7fff_ffff;
				1: r.word = 32'h8000_0000;
				2: r.word = 32'hffff_ffff;
				default: r.word = 32'h0;
			endcase
		end else begin
			span = (magnitude(value_db) > 1000) ? 1000 : magnitude(value_db) + 2;
			t = longint'($signed(gen_last)) + longint'($urandom_range(0, 2 * span)) - span;
			r.word = t[31:0];
		end
		gen_last = r.word;
		return r;
	endfunction

	task automatic push_request(input logic [31:0] word, input logic defined);
		status_request_t r;
		r.word = word;
		r.defined = defined;
		pending_requests.push_back(r);
	endtask

	task automatic apb_write(input reg_idx_t idx, input logic [31:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_HIHI:     lim_hihi = longint'($signed(data));
			REG_HIGH:     lim_high = longint'($signed(data));
			REG_LOW:      lim_low = longint'($signed(data));
			REG_LOLO:     lim_lolo = longint'($signed(data));
			REG_HYST:     hyst_band = longint'(data[30:0]);
			REG_SEVS:     sev_map = data[7:0];
			REG_VALUE_DB: value_db = longint'($signed(data));
			REG_ARCH_DB:  archive_db = longint'($signed(data));
		endcase
	endtask

	task automatic write_limits(input logic [31:0] regs[8]);
		int i;
		for (i = 0; i < 8; i++)
			apb_write(reg_idx_t'(i), regs[i]);
	endtask

	task automatic drain_and_settle();
		do @(negedge clk);
		while (pending_requests.size() != 0 || in_valid || expected_alarms.size() != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic run_random(input int count);
		int i;
		for (i = 0; i < count; i++)
			pending_requests.push_back(random_request());
		drain_and_settle();
	endtask

	// request driver
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				grade_request(value, value_defined);
				words_accepted <= words_accepted + 1;
			end
			if (!in_valid || in_ready) begin
				if (send_gap != 0) begin
					send_gap <= send_gap - 1;
					in_valid <= 1'b0;
				end else if (!calm && $urandom_range(0, 7) == 0) begin
					send_gap <= $urandom_range(0, 10);
					in_valid <= 1'b0;
				end else if (pending_requests.size() != 0) begin
					next_request = pending_requests.pop_front();
					value <= next_request.word;
					value_defined <= next_request.defined;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// long receiver hold-off
	always @(posedge clk) begin
		if (!arst_n) begin
			hold_left <= 0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (!hold_done && words_accepted >= 400) begin
			hold_done <= 1'b1;
			hold_left <= 80;
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_alarms.size() == 0) begin
					$display("%0t: result with no request pending, expected none, actual status %0d",
						$time, alarm_status);
					fail_count++;
				end else begin
					oldest = expected_alarms.pop_front();
					check_field("alarm_status", oldest.status, alarm_status);
					check_field("alarm_severity", oldest.severity, alarm_severity);
					check_field("alarm_changed", oldest.changed, alarm_changed);
					check_field("value_event", oldest.value_ev, value_event);
					check_field("archive_event", oldest.archive_ev, archive_event);
					check_field("link_mask", oldest.links, link_mask);
				end
			end
			if (hold_left != 0) begin
				out_ready <= 1'b0;
			end else if (ready_gap != 0) begin
				ready_gap <= ready_gap - 1;
				out_ready <= 1'b0;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				ready_gap <= $urandom_range(0, 10);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin
		#5ms;
		$display("tb: failure");
		$finish;
	end

	initial begin
		logic [31:0] regs[8];
		longint      center, spread, t;
		int          phase;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// all checks off, zero deadbands
		run_random(20);

		regs = '{32'd100, 32'd50, -32'sd50, -32'sd100, 32'd10, 32'h5a, 32'd5,
			32'hffff_ffff};
		write_limits(regs);
		push_request(32'd0, 1'b1);
		push_request(32'd100, 1'b1);
		push_request(32'd91, 1'b1);
		push_request(32'd89, 1'b1);
		push_request(32'd41, 1'b1);
		push_request(32'd39, 1'b1);
		push_request(-32'sd50, 1'b1);
		push_request(-32'sd41, 1'b1);
		push_request(-32'sd39, 1'b1);
		push_request(-32'sd100, 1'b1);
		push_request(-32'sd90, 1'b1);
		push_request(-32'sd89, 1'b1);
		push_request(32'd7, 1'b0);
		push_request(32'd7, 1'b1);
		push_request(32'h7fff_ffff, 1'b1);
		push_request(32'h8000_0000, 1'b1);
		push_request(32'hffff_ffff, 1'b1);
		push_request(32'h0, 1'b0);
		push_request(32'h8000_0000, 1'b0);
		push_request(32'd3, 1'b1);
		push_request(32'd4, 1'b1);
		push_request(32'd12, 1'b1);
		drain_and_settle();

		regs = '{32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000,
			32'hffff_ffff, 32'hff, 32'h7fff_ffff, 32'h8000_0000};
		write_limits(regs);
		run_random(40);

		regs = '{32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
			32'h0, 32'hff, 32'h8000_0000, 32'h7fff_ffff};
		write_limits(regs);
		run_random(40);

		for (phase = 0; phase < 9; phase++) begin
			if ($urandom_range(0, 3) == 0) begin
				regs[REG_HIHI] = $urandom;
				regs[REG_HIGH] = $urandom;
				regs[REG_LOW] = $urandom;
				regs[REG_LOLO] = $urandom;
			end else begin
				center = longint'($signed($urandom)) >>> 2;
				spread = $urandom_range(0, 2000);
				t = center + 2 * spread + $urandom_range(0, 50);
				regs[REG_HIHI] = t[31:0];
				t = center + spread;
				regs[REG_HIGH] = t[31:0];
				t = center - spread;
				regs[REG_LOW] = t[31:0];
				t = center - 2 * spread - $urandom_range(0, 50);
				regs[REG_LOLO] = t[31:0];
			end
			regs[REG_HYST] = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 200);
			regs[REG_SEVS] = $urandom;
			regs[REG_VALUE_DB] = ($urandom_range(0, 4) == 0) ? $urandom :
				$urandom_range(0, 300) - 32'd20;
			regs[REG_ARCH_DB] = ($urandom_range(0, 4) == 0) ? $urandom :
				$urandom_range(0, 600) - 32'd20;
			write_limits(regs);
			if (phase == 8)
				calm <= 1'b1;
			run_random(165);
		end

		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

>>> filelist.f
+incdir+hdl
hdl/swam_pkg.sv
hdl/swam_regs.sv
hdl/swam_grade.sv
hdl/status_word_alarm_monitor_core.sv
hdl/swam_check.sv
tb/sv/tb_status_word_alarm_monitor_core.sv
